// File: src/ubt_pkg.sv
// Package: shared types and constants for the UART bit-bang transmitter.
package ubt_pkg;

  localparam int unsigned FRAME_LEN  = 10;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd278;
  localparam logic [IDX_W-1:0]    LAST_IDX     = 4'(FRAME_LEN - 1);

  typedef logic [FRAME_LEN-1:0] frame_t;

  typedef enum logic [1:0] {
    REG_PARITY_MODE = 2'd0,
    REG_BIT_PERIOD  = 2'd1,
    REG_TX_ENABLED  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PAR_NONE  = 2'd0,
    PAR_EVEN  = 2'd1,
    PAR_ODD   = 2'd2,
    PAR_NONE3 = 2'd3
  } parity_mode_t;

endpackage

// File: src/ubt_if.sv
// Interfaces: byte input channel and line symbol result channel.
interface ubt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface ubt_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic drive_enable;
  logic last_symbol;

  modport source (output valid, output line_level, output drive_enable,
                  output last_symbol, input ready);
  modport sink   (input valid, input line_level, input drive_enable,
                  input last_symbol, output ready);
endinterface

// File: src/uart_bitbang_transmitter_top.sv
// Top level: APB-configured UART transmitter with inverted line polarity.
// Each accepted byte yields ten symbol transactions (start, data, optional
// parity, stop), paced by the symbol tick counter from bit_period (zero acts
// as one); the result side can stall them. One byte waits in a holding
// register while the previous run is sent, and bytes are dropped while
// tx_enabled is 0.
// Symbol values do not depend on bit_period, only their timing does.
module uart_bitbang_transmitter_top
  import ubt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ubt_in_if.sink                in_ch,
  ubt_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  parity_mode_t        parity_mode_r;
  logic [PERIOD_W-1:0] bit_period_r;
  logic                tx_enabled_r;

  logic                hold_vld_r, hold_vld_nxt;
  frame_t              hold_frame_r;
  logic                hold_eom_r;

  logic                sh_vld_r, sh_vld_nxt;
  frame_t              sh_frame_r;
  logic [IDX_W-1:0]    sh_idx_r;
  logic                sh_eom_r;
  logic [PERIOD_W-1:0] tick_r;
  logic                msg_r;

  logic                out_vld_r;
  logic                out_line_r;
  logic                out_de_r;
  logic                out_last_r;

  frame_t              in_frame;
  reg_idx_t            cfg_idx;
  logic                cfg_wr;
  logic [PERIOD_W-1:0] period_m1;
  logic                tick_done;
  logic                emit;
  logic                last_emit;
  logic                hold_load;
  logic                in_take;

  ubt_frame u_frame (
    .data_byte   (in_ch.data_byte),
    .parity_mode (parity_mode_r),
    .frame       (in_frame)
  );

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      REG_PARITY_MODE: cfg_prdata = {30'd0, parity_mode_r};
      REG_BIT_PERIOD:  cfg_prdata = {16'd0, bit_period_r};
      REG_TX_ENABLED:  cfg_prdata = {31'd0, tx_enabled_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_mode_r <= PAR_NONE;
      bit_period_r  <= PERIOD_RESET;
      tx_enabled_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PARITY_MODE: parity_mode_r <= parity_mode_t'(cfg_pwdata[1:0]);
        REG_BIT_PERIOD:  bit_period_r  <= cfg_pwdata[PERIOD_W-1:0];
        REG_TX_ENABLED:  tx_enabled_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  assign period_m1 = (bit_period_r == '0) ? '0 : bit_period_r - 1'b1;
  assign tick_done = (tick_r == period_m1);
  assign emit      = sh_vld_r && tick_done && (!out_vld_r || out_ch.ready);
  assign last_emit = emit && (sh_idx_r == LAST_IDX);
  assign hold_load = hold_vld_r && (!sh_vld_r || last_emit);
  assign in_ch.ready = !hold_vld_r || hold_load;
  assign in_take   = in_ch.valid && in_ch.ready;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (hold_load) begin
      hold_vld_nxt = 1'b0;
    end
    if (in_take && tx_enabled_r) begin
      hold_vld_nxt = 1'b1;
    end
    sh_vld_nxt = sh_vld_r;
    if (hold_load) begin
      sh_vld_nxt = 1'b1;
    end else if (last_emit) begin
      sh_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      sh_vld_r   <= 1'b0;
      sh_idx_r   <= '0;
      tick_r     <= '0;
      msg_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      sh_vld_r   <= sh_vld_nxt;
      if (hold_load) begin
        sh_idx_r <= '0;
        tick_r   <= '0;
        msg_r    <= 1'b1;
      end else begin
        if (emit) begin
          sh_idx_r <= sh_idx_r + 1'b1;
          tick_r   <= '0;
        end else if (sh_vld_r && !tick_done) begin
          tick_r <= tick_r + 1'b1;
        end
        if (last_emit && sh_eom_r) begin
          msg_r <= 1'b0;
        end else if (in_take && !tx_enabled_r && !sh_vld_r && !hold_vld_r) begin
          msg_r <= 1'b0;
        end
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && tx_enabled_r) begin
      hold_frame_r <= in_frame;
      hold_eom_r   <= in_ch.end_of_message;
    end
    if (hold_load) begin
      sh_frame_r <= hold_frame_r;
      sh_eom_r   <= hold_eom_r;
    end else if (emit) begin
      sh_frame_r <= {1'b0, sh_frame_r[FRAME_LEN-1:1]};
    end
    if (emit) begin
      out_line_r <= sh_frame_r[0];
      out_de_r   <= msg_r;
      out_last_r <= (sh_idx_r == LAST_IDX);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.line_level   = out_line_r;
  assign out_ch.drive_enable = out_de_r;
  assign out_ch.last_symbol  = out_last_r;

endmodule

// File: src/ubt_frame.sv
// Frame builder: turns one byte into the ten inverted line levels of its run.
module ubt_frame
  import ubt_pkg::*;
(
  input  logic [7:0]   data_byte,
  input  parity_mode_t parity_mode,
  output frame_t       frame
);

  logic with_parity;
  logic pbit;

  always_comb begin
    with_parity = (parity_mode == PAR_EVEN) || (parity_mode == PAR_ODD);
    pbit        = (parity_mode == PAR_EVEN) ? (^data_byte[6:0]) : ~(^data_byte[6:0]);
    frame[0]    = 1'b1;
    frame[7:1]  = ~data_byte[6:0];
    frame[8]    = with_parity ? ~pbit : ~data_byte[7];
    frame[9]    = 1'b0;
  end

endmodule

// File: src/ubt_checker.sv
// Checker: port-level assertions for the transmitter, bound to the top level.
module ubt_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_line_level,
  input logic out_drive_enable,
  input logic out_last_symbol,
  input logic cfg_pready
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_level)
      && $stable(out_last_symbol))
    else $error("stalled symbol transaction changed");

  a_drive_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_enable)
    else $error("symbol sent with driver disabled");

  a_stop_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_symbol |-> !out_line_level)
    else $error("stop symbol not low");

  a_no_valid_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("symbol valid right after reset");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready dropped");

endmodule

bind uart_bitbang_transmitter_top ubt_checker u_ubt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_line_level   (out_ch.line_level),
  .out_drive_enable (out_ch.drive_enable),
  .out_last_symbol  (out_ch.last_symbol),
  .cfg_pready       (cfg_pready)
);
